@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication or plain property, checked on every rising edge out of reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen on a rising edge out of reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ rtl/core/odr_pkg.sv @@
// ----------------------------------------------------------------------------
// Dead reckoning package
// Widths, request and motion codes, CORDIC table and saturation helper.
// ----------------------------------------------------------------------------
package odr_pkg;

  localparam int POS_W   = 32;          // Q16.16 position
  localparam int ANG_W   = 16;          // turn fraction
  localparam int GUARD   = 8;           // CORDIC guard bits
  localparam int STEPS   = 24;          // CORDIC iterations
  localparam int STEP_W  = 5;
  localparam int CW      = 44;          // CORDIC x/y datapath
  localparam int ZW      = 34;          // CORDIC angle accumulator
  localparam int SUM_W   = POS_W + 5;   // widened sum before clamp
  localparam int DIG_W   = 4;           // multiplier digit
  localparam int DIGITS  = 8;           // digits in the gain constant
  localparam int CNT_W   = 3;
  localparam logic [31:0] KINV = 32'd2608131496;

  typedef logic [1:0] req_t;
  localparam req_t REQ_ODO  = 2'd0;
  localparam req_t REQ_GYRO = 2'd1;
  localparam req_t REQ_TICK = 2'd2;
  localparam req_t REQ_POSE = 2'd3;

  typedef logic [1:0] motion_t;
  localparam motion_t MOTION_STILL = 2'd0;
  localparam motion_t MOTION_FWD   = 2'd1;
  localparam motion_t MOTION_REV   = 2'd2;

  localparam logic [ANG_W-1:0] HALF_TURN = {1'b1, {(ANG_W-1){1'b0}}};

  typedef struct packed {
    logic start;
    logic rotate;
  } cor_ctrl_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933408;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return {{(ZW-32){1'b0}}, v};
  endfunction

  // clamp a widened sum to the signed position range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    lo = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage

@@ rtl/core/odometry_imu_dead_reckoning_unit.sv @@
// ----------------------------------------------------------------------------
// Odometry and IMU dead reckoning unit
// Fuses wheel odometry and gyro yaw into a 2-D pose estimate.
// ----------------------------------------------------------------------------
// Usage: one item enters on the s_axis channel; s_axis_tuser carries the
// request kind (odometry, gyro, tick, pose reset) and s_axis_tdata the fields.
// Every item yields exactly one pose transaction on m_axis (x, y, heading).
// Odometry, gyro, pose reset and ticks with no new odometry go from accept
// straight to the publish state. A tick with new odometry runs the travel
// path: 24 vectoring steps and 24 rotation steps of one shared CORDIC, plus
// two digit-serial gain multiplies, and that path sets the throughput.
// One item is in work at a time: s_axis_tready is high
// only while the sequencer idles. A finished result sits in the output
// register, so the next item is taken while m_axis waits; a second result
// holds in the publish state until the receiver takes the first.
// The cfg channel writes the odometry-only default; it is always ready and
// also reloads the heading mode. Reset clears the estimator state, sets
// default and heading mode to odometry-only and empties the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module odometry_imu_dead_reckoning_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // odo_x, odo_y, odo_yaw, forward_speed, turn_rate, imu_yaw, set_x, set_y, set_heading
  input  logic [207:0] s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pose_x, pose_y, pose_heading
  output logic [79:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  import odr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_VEC  = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_ROT  = 6'b010000,
    ST_PUB  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // input fields
  logic signed [POS_W-1:0] odo_x, odo_y, set_x, set_y;
  logic [ANG_W-1:0]        odo_yaw, imu_yaw, set_heading;
  logic [15:0]             forward_speed, turn_rate;
  req_t                    req_type;

  // estimator state
  logic                    odo_only_default, odo_only_mode;
  logic signed [POS_W-1:0] prev_odo_x, prev_odo_y, sum_dx, sum_dy, est_x, est_y;
  logic [ANG_W-1:0]        prev_odo_heading, prev_gyro_yaw, gyro_offset, est_heading;
  logic [ANG_W-1:0]        travel_ang;
  logic                    seen_first_odo, odo_pending, gyro_pending;
  motion_t                 motion_status;

  logic                    accept;
  logic                    travel_go;
  logic [ANG_W-1:0]        hd_next, off_next, ang_next, expect_yaw;
  motion_t                 motion_next;
  logic [POS_W-1:0]        sdx_next, sdy_next;

  cor_ctrl_t               cor_ctrl;
  logic signed [CW-1:0]    cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0]    cor_z0;
  logic                    cor_done;
  logic                    mul_start, mul_done;
  logic [CW-1:0]           mul_a, mul_p;

  logic [POS_W:0]          abs_dx, abs_dy;
  logic [31:0]             rot_a;
  logic                    rot_flip;
  logic [POS_W-1:0]        est_x_next, est_y_next;

  assign odo_x         = s_axis_tdata[31:0];
  assign odo_y         = s_axis_tdata[63:32];
  assign odo_yaw       = s_axis_tdata[79:64];
  assign forward_speed = s_axis_tdata[95:80];
  assign turn_rate     = s_axis_tdata[111:96];
  assign imu_yaw       = s_axis_tdata[127:112];
  assign set_x         = s_axis_tdata[159:128];
  assign set_y         = s_axis_tdata[191:160];
  assign set_heading   = s_axis_tdata[207:192];
  assign req_type      = s_axis_tuser;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign travel_go     = accept && req_type == REQ_TICK && odo_pending;

  // accumulate odometry deltas with clamping
  always_comb begin
    logic signed [SUM_W-1:0] dx, dy;
    dx = SUM_W'(odo_x) - SUM_W'(prev_odo_x) + SUM_W'(sum_dx);
    dy = SUM_W'(odo_y) - SUM_W'(prev_odo_y) + SUM_W'(sum_dy);
    sdx_next = sat_pos(dx);
    sdy_next = sat_pos(dy);
  end

  // classify motion from speed sign and turn rate
  always_comb begin
    if (forward_speed != '0 && !forward_speed[15]) begin
      motion_next = MOTION_FWD;
    end else if (forward_speed != '0) begin
      motion_next = MOTION_REV;
    end else if (turn_rate == '0) begin
      motion_next = MOTION_STILL;
    end else begin
      motion_next = MOTION_REV;
    end
  end

  // tick heading: follow gyro while moving, re-derive offset at standstill, use odometry yaw in odometry-only mode
  always_comb begin
    hd_next    = est_heading;
    off_next   = gyro_offset;
    expect_yaw = prev_gyro_yaw + gyro_offset;
    if (gyro_pending) begin
      if (motion_status != MOTION_STILL) begin
        hd_next = expect_yaw;
      end else begin
        off_next = gyro_offset - (expect_yaw - est_heading);
      end
    end
    if (odo_pending && odo_only_mode) begin
      hd_next = prev_odo_heading;
    end
    ang_next = (motion_status != MOTION_FWD) ? hd_next + HALF_TURN : hd_next;
  end

  // CORDIC operands: magnitudes for vectoring, folded angle for rotation
  always_comb begin
    abs_dx   = sum_dx[POS_W-1] ? -{sum_dx[POS_W-1], sum_dx} : {sum_dx[POS_W-1], sum_dx};
    abs_dy   = sum_dy[POS_W-1] ? -{sum_dy[POS_W-1], sum_dy} : {sum_dy[POS_W-1], sum_dy};
    rot_a    = {travel_ang, {(32-ANG_W){1'b0}}};
    rot_flip = rot_a[31] ^ rot_a[30];
    if (rot_flip) begin
      rot_a[31] = ~rot_a[31];
    end
    cor_ctrl.start  = travel_go || (state == ST_MUL2 && mul_done);
    cor_ctrl.rotate = (state == ST_MUL2);
    if (state == ST_MUL2) begin
      cor_x0 = rot_flip ? -$signed(mul_p) : $signed(mul_p);
      cor_y0 = '0;
      cor_z0 = {{(ZW-32){rot_a[31]}}, rot_a};
    end else begin
      cor_x0 = {{(CW-POS_W-1-GUARD){1'b0}}, abs_dx, {GUARD{1'b0}}};
      cor_y0 = {{(CW-POS_W-1-GUARD){1'b0}}, abs_dy, {GUARD{1'b0}}};
      cor_z0 = '0;
    end
    mul_start = (state == ST_VEC && cor_done) || (state == ST_MUL1 && mul_done);
    mul_a     = (state == ST_VEC) ? cor_x : mul_p;
  end

  // add the rotated step to the pose, dropping guard bits by floor
  always_comb begin
    logic signed [SUM_W-1:0] sx, sy;
    sx = SUM_W'($signed(cor_x[CW-1:GUARD])) + SUM_W'(est_x);
    sy = SUM_W'($signed(cor_y[CW-1:GUARD])) + SUM_W'(est_y);
    est_x_next = sat_pos(sx);
    est_y_next = sat_pos(sy);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = travel_go ? ST_VEC : ST_PUB;
      ST_VEC:  if (cor_done) state_next = ST_MUL1;
      ST_MUL1: if (mul_done) state_next = ST_MUL2;
      ST_MUL2: if (mul_done) state_next = ST_ROT;
      ST_ROT:  if (cor_done) state_next = ST_PUB;
      ST_PUB:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // estimator state update
  always_ff @(posedge clk) begin
    if (rst) begin
      odo_only_default <= 1'b1;
      odo_only_mode    <= 1'b1;
      prev_odo_x       <= '0;
      prev_odo_y       <= '0;
      prev_odo_heading <= '0;
      prev_gyro_yaw    <= '0;
      gyro_offset      <= '0;
      est_heading      <= '0;
      est_x            <= '0;
      est_y            <= '0;
      sum_dx           <= '0;
      sum_dy           <= '0;
      motion_status    <= MOTION_STILL;
      seen_first_odo   <= 1'b0;
      odo_pending      <= 1'b0;
      gyro_pending     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        odo_only_default <= cfg_data;
        odo_only_mode    <= cfg_data;
      end
      if (accept) begin
        unique case (req_type)
          REQ_ODO: begin
            if (seen_first_odo) begin
              sum_dx <= sdx_next;
              sum_dy <= sdy_next;
            end
            seen_first_odo   <= 1'b1;
            prev_odo_x       <= odo_x;
            prev_odo_y       <= odo_y;
            prev_odo_heading <= odo_yaw;
            motion_status    <= motion_next;
            odo_pending      <= 1'b1;
          end
          REQ_GYRO: begin
            odo_only_mode <= 1'b0;
            prev_gyro_yaw <= imu_yaw;
            gyro_pending  <= 1'b1;
          end
          REQ_TICK: begin
            est_heading  <= hd_next;
            gyro_offset  <= off_next;
            gyro_pending <= 1'b0;
            if (odo_pending) begin
              odo_pending <= 1'b0;
              sum_dx      <= '0;
              sum_dy      <= '0;
            end
          end
          REQ_POSE: begin
            est_x       <= set_x;
            est_y       <= set_y;
            est_heading <= set_heading;
          end
          default: ;
        endcase
      end
      if (state == ST_ROT && cor_done) begin
        est_x <= est_x_next;
        est_y <= est_y_next;
      end
    end
  end

  // hold the travel angle for the rotation pass
  always_ff @(posedge clk) begin
    if (travel_go) begin
      travel_ang <= ang_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_PUB && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUB && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {est_heading, est_y, est_x};
    end
  end

  odr_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cor_ctrl),
    .x0   (cor_x0),
    .y0   (cor_y0),
    .z0   (cor_z0),
    .done (cor_done),
    .x    (cor_x),
    .y    (cor_y)
  );

  odr_sermul u_sermul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .done  (mul_done),
    .p     (mul_p)
  );

  `ASSERT_CLK(a_cor_done_state, clk, rst, cor_done |-> (state == ST_VEC || state == ST_ROT), "CORDIC finished outside a CORDIC pass")
  `ASSERT_CLK(a_mul_done_state, clk, rst, mul_done |-> (state == ST_MUL1 || state == ST_MUL2), "multiplier finished outside a gain pass")
  `ASSERT_CLK(a_sums_cleared, clk, rst, travel_go |=> (sum_dx == '0 && sum_dy == '0), "travel started without clearing the sums")
  `ASSERT_CLK(a_cfg_default_loaded, clk, rst, (cfg_valid && cfg_ready) |=> (odo_only_default == $past(cfg_data)), "config write dropped")

endmodule

@@ rtl/core/odr_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC
// One micro-rotation per cycle, shared between vectoring and rotation.
// ----------------------------------------------------------------------------
module odr_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  odr_pkg::cor_ctrl_t           ctrl,
  input  logic signed [odr_pkg::CW-1:0] x0,
  input  logic signed [odr_pkg::CW-1:0] y0,
  input  logic signed [odr_pkg::ZW-1:0] z0,
  output logic                         done,
  output logic signed [odr_pkg::CW-1:0] x,
  output logic signed [odr_pkg::CW-1:0] y
);
  import odr_pkg::*;

  logic signed [ZW-1:0] z;
  logic [STEP_W-1:0]    step;
  logic                 busy;
  logic                 rotate;
  logic                 ccw;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;

  // pick direction: rotation follows the residual angle, vectoring drives y to zero
  always_comb begin
    xs  = x >>> step;
    ys  = y >>> step;
    at  = atan_turn(step);
    ccw = rotate ? !z[ZW-1] : (y <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // load operands, then advance one step per cycle
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x      <= x0;
      y      <= y0;
      z      <= z0;
      rotate <= ctrl.rotate;
      step   <= '0;
    end else if (busy) begin
      x    <= ccw ? x - ys : x + ys;
      y    <= ccw ? y + xs : y - xs;
      z    <= ccw ? z - at : z + at;
      step <= step + 1'b1;
    end
  end

endmodule

@@ rtl/core/odr_sermul.sv @@
// ----------------------------------------------------------------------------
// Digit-serial gain multiplier
// Computes floor(a * KINV / 2^32), four bits of the constant per cycle.
// ----------------------------------------------------------------------------
module odr_sermul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [odr_pkg::CW-1:0] a_in,
  output logic                   done,
  output logic [odr_pkg::CW-1:0] p
);
  import odr_pkg::*;

  logic [CW-1:0]       a;
  logic [CW+DIG_W-1:0] acc;
  logic [CW+DIG_W-1:0] acc_sum;
  logic [31:0]         kdig;
  logic [CNT_W-1:0]    cnt;
  logic                busy;

  // add one partial product; the shift right keeps the running floor
  assign acc_sum = acc + (CW + DIG_W)'(a) * (CW + DIG_W)'(kdig[DIG_W-1:0]);
  assign p       = acc[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIGITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= a_in;
      acc  <= '0;
      kdig <= KINV;
      cnt  <= '0;
    end else if (busy) begin
      acc  <= acc_sum >> DIG_W;
      kdig <= kdig >> DIG_W;
      cnt  <= cnt + 1'b1;
    end
  end

endmodule
